[design/msrpd_pkg.sv]
// Shared constants for the residue pair distance score block: field widths,
// request and status codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package msrpd_pkg;

    localparam int REQ_W      = 3;
    localparam int ROW_W      = 4;
    localparam int COLUMN_W   = 10;
    localparam int DIST_W     = 24;
    localparam int SCORE_W    = 28;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int NSEQ_W     = 5;
    localparam int NCOL_W     = 11;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SCORE_W-1:0]  score_t;

    localparam req_t REQ_LOAD_BASE = 3'd0;
    localparam req_t REQ_LOAD_TEST = 3'd1;
    localparam req_t REQ_LOAD_DIST = 3'd2;
    localparam req_t REQ_COMPUTE   = 3'd3;
    localparam req_t REQ_READ      = 3'd4;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_SCORE = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_SEQS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_COLS = 2'd2;

    localparam logic [NSEQ_W-1:0] NUM_SEQS_RST = 5'd16;
    localparam logic [NCOL_W-1:0] COLS_RST     = 11'd1024;

    localparam score_t SCORE_MAX = '1;

endpackage

`default_nettype wire

[design/msrpd_ram.sv]
// Simple dual port synchronous RAM: one write port, one read port with a
// registered read. Uses msrpd_pkg for nothing but style.
`default_nettype none

module msrpd_ram
    import msrpd_pkg::*;
#(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/msa_residue_pair_distance_scores.sv]
// Top level of the residue pair distance score block: request decode, control
// sequencer and five msrpd_ram stores. Depends on msrpd_pkg and msrpd_ram.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, req_type .. distance  | request in
//   out     | out_valid, out_stall, score, status       | result out
//   cfg     | cfg_wr_en, cfg_index, cfg_data            | register write
//
// Loads and unknown requests are answered from idle; an in-range score read
// passes through S_RD for the registered score RAM read. Compute first clears
// all 2^(SEQ_W+COL_W) score cells (16384 by default), then walks rows and
// columns to pair residues, then per test column loads the column map and,
// per mapped row, sums the distances of the rows sharing its base column one
// at a time over the single distance RAM port; unmapped rows are skipped.
// After reset the score store is cleared the same way; requests stall meanwhile.
// A result waits in the output register; a new request is taken as it leaves.
`default_nettype none

module msa_residue_pair_distance_scores
    import msrpd_pkg::*;
#(
    parameter int MAX_SEQS = 16,
    parameter int MAX_COLS = 1024
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [ROW_W-1:0]      row,
    input  wire logic [COLUMN_W-1:0]   column,
    input  wire logic [ROW_W-1:0]      other_row,
    input  wire logic                  is_residue,
    input  wire logic [DIST_W-1:0]     distance,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [SCORE_W-1:0]         score,
    output logic [STATUS_W-1:0]        status
);

    localparam int SEQ_W   = $clog2(MAX_SEQS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int CELL_W  = SEQ_W + COL_W;
    localparam int PAIR_W  = 2 * SEQ_W;
    localparam int CNT_S_W = SEQ_W + 1;
    localparam int CNT_C_W = COL_W + 1;
    localparam int SUM_W   = DIST_W + SEQ_W + 1;
    localparam int TOT_W   = ((SUM_W > SCORE_W) ? SUM_W : SCORE_W) + 1;
    localparam int MAP_W   = COL_W + 1;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_MAP_RA = 4'd3;
    localparam logic [3:0] S_MAP_EV = 4'd4;
    localparam logic [3:0] S_COL_RA = 4'd5;
    localparam logic [3:0] S_COL_RB = 4'd6;
    localparam logic [3:0] S_SEL    = 4'd7;
    localparam logic [3:0] S_ACC_RA = 4'd8;
    localparam logic [3:0] S_ACC_RB = 4'd9;
    localparam logic [3:0] S_SC_WB  = 4'd10;

    // configuration
    logic [NSEQ_W-1:0] num_seqs_reg;
    logic [NCOL_W-1:0] base_cols_reg;
    logic [NCOL_W-1:0] test_cols_reg;
    logic [CNT_S_W-1:0] n_eff;
    logic [CNT_C_W-1:0] bc_eff;
    logic [CNT_C_W-1:0] tc_eff;

    // control
    logic [3:0]          state_reg, state_next;
    logic                cmp_reg, cmp_next;
    logic [CELL_W-1:0]   clr_reg, clr_next;
    logic [CNT_S_W-1:0]  r_reg, r_next;
    logic [CNT_S_W-1:0]  i_reg, i_next;
    logic [CNT_C_W-1:0]  b_reg, b_next;
    logic [CNT_C_W-1:0]  s_reg, s_next;
    logic [CNT_C_W-1:0]  t_reg, t_next;
    logic                out_valid_reg, out_valid_next;

    // datapath
    logic [COL_W-1:0]    x_reg, x_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [MAX_SEQS-1:0] mask_reg, mask_next;
    logic [MAX_SEQS-1:0] lane_valid_reg, lane_valid_next;
    logic [COL_W-1:0]    lane_col_reg [MAX_SEQS];
    logic [COL_W-1:0]    lane_col_next [MAX_SEQS];
    score_t              score_reg, score_next;
    status_t             status_reg, status_next;

    // memory ports
    logic               base_we, test_we, dist_we, map_we, score_we;
    logic [CELL_W-1:0]  base_waddr, test_waddr, map_waddr, score_waddr;
    logic [CELL_W-1:0]  base_raddr, test_raddr, map_raddr, score_raddr;
    logic [PAIR_W-1:0]  dist_waddr, dist_raddr;
    logic [MAP_W-1:0]   map_wdata, map_rdata;
    score_t             score_wdata, score_rdata;
    logic               base_rdata, test_rdata;
    logic [DIST_W-1:0]  dist_rdata;

    // request decode helpers
    logic              in_acc;
    logic              row_ok, orow_ok, colb_ok, colt_ok;
    logic [CELL_W-1:0] cell_in;
    logic [SEQ_W-1:0]  r_idx;
    logic              b_in;
    logic [TOT_W-1:0]  total;

    assign n_eff  = (32'(num_seqs_reg) > 32'(MAX_SEQS)) ? CNT_S_W'(MAX_SEQS)
                                                         : CNT_S_W'(num_seqs_reg);
    assign bc_eff = (32'(base_cols_reg) > 32'(MAX_COLS)) ? CNT_C_W'(MAX_COLS)
                                                          : CNT_C_W'(base_cols_reg);
    assign tc_eff = (32'(test_cols_reg) > 32'(MAX_COLS)) ? CNT_C_W'(MAX_COLS)
                                                          : CNT_C_W'(test_cols_reg);

    assign row_ok  = 32'(row) < 32'(n_eff);
    assign orow_ok = 32'(other_row) < 32'(n_eff);
    assign colb_ok = 32'(column) < 32'(bc_eff);
    assign colt_ok = 32'(column) < 32'(tc_eff);
    assign cell_in = {SEQ_W'(row), COL_W'(column)};
    assign r_idx   = SEQ_W'(r_reg);
    assign b_in    = b_reg < bc_eff;
    assign total   = TOT_W'(sum_reg) + TOT_W'(score_rdata);

    // hold requests while busy or while the result slot stays blocked
    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign score     = score_reg;
    assign status    = status_reg;

    // fixed write data and addresses of the load stores
    assign base_waddr = cell_in;
    assign test_waddr = cell_in;
    assign dist_waddr = {SEQ_W'(row), SEQ_W'(other_row)};

    // sequencer
    always_comb
    begin
        int k;
        state_next      = state_reg;
        cmp_next        = cmp_reg;
        clr_next        = clr_reg;
        r_next          = r_reg;
        i_next          = i_reg;
        b_next          = b_reg;
        s_next          = s_reg;
        t_next          = t_reg;
        x_next          = x_reg;
        sum_next        = sum_reg;
        mask_next       = mask_reg;
        lane_valid_next = lane_valid_reg;
        lane_col_next   = lane_col_reg;
        out_valid_next  = out_valid_reg && out_stall;
        score_next      = score_reg;
        status_next     = status_reg;
        base_we         = 1'b0;
        test_we         = 1'b0;
        dist_we         = 1'b0;
        map_we          = 1'b0;
        score_we        = 1'b0;
        map_waddr       = {r_idx, COL_W'(s_reg)};
        map_wdata       = '0;
        score_waddr     = clr_reg;
        score_wdata     = '0;
        base_raddr      = {r_idx, COL_W'(b_reg)};
        test_raddr      = {r_idx, COL_W'(s_reg)};
        map_raddr       = {SEQ_W'(i_reg), COL_W'(t_reg)};
        score_raddr     = cell_in;
        dist_raddr      = {SEQ_W'(i_reg), r_idx};

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    out_valid_next = 1'b1;
                    score_next     = '0;
                    status_next    = STATUS_RANGE;
                    case (req_type)
                        REQ_LOAD_BASE:
                        begin
                            if (row_ok && colb_ok)
                            begin
                                base_we     = 1'b1;
                                status_next = STATUS_OK;
                            end
                        end
                        REQ_LOAD_TEST:
                        begin
                            if (row_ok && colt_ok)
                            begin
                                test_we     = 1'b1;
                                status_next = STATUS_OK;
                            end
                        end
                        REQ_LOAD_DIST:
                        begin
                            if (row_ok && orow_ok)
                            begin
                                dist_we     = 1'b1;
                                status_next = STATUS_OK;
                            end
                        end
                        REQ_COMPUTE:
                        begin
                            out_valid_next = 1'b0;
                            cmp_next       = 1'b1;
                            clr_next       = '0;
                            state_next     = S_CLEAR;
                        end
                        REQ_READ:
                        begin
                            if (row_ok && colb_ok)
                            begin
                                out_valid_next = 1'b0;
                                state_next     = S_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                out_valid_next = 1'b1;
                score_next     = score_rdata;
                status_next    = STATUS_SCORE;
                state_next     = S_IDLE;
            end
            S_CLEAR:
            begin
                score_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    r_next     = '0;
                    b_next     = '0;
                    s_next     = '0;
                    state_next = cmp_reg ? S_MAP_RA : S_IDLE;
                end
            end
            // pairing walk: issue flag reads for the current row
            S_MAP_RA:
            begin
                if (r_reg >= n_eff)
                begin
                    t_next     = '0;
                    i_next     = '0;
                    state_next = S_COL_RA;
                end
                else if (s_reg >= tc_eff)
                begin
                    r_next = r_reg + 1'b1;
                    b_next = '0;
                    s_next = '0;
                end
                else
                begin
                    state_next = S_MAP_EV;
                end
            end
            // advance over gaps, pair residues, leave leftovers unmapped
            S_MAP_EV:
            begin
                if (b_in && !base_rdata)
                begin
                    b_next = b_reg + 1'b1;
                end
                if (!test_rdata || !b_in)
                begin
                    map_we = 1'b1;
                    s_next = s_reg + 1'b1;
                end
                else if (base_rdata)
                begin
                    map_we    = 1'b1;
                    map_wdata = {1'b1, COL_W'(b_reg)};
                    s_next    = s_reg + 1'b1;
                    b_next    = b_reg + 1'b1;
                end
                state_next = S_MAP_RA;
            end
            // load the map of one test column into the lanes
            S_COL_RA:
            begin
                if (t_reg >= tc_eff)
                begin
                    cmp_next       = 1'b0;
                    out_valid_next = 1'b1;
                    score_next     = '0;
                    status_next    = STATUS_OK;
                    state_next     = S_IDLE;
                end
                else if (i_reg >= n_eff)
                begin
                    r_next     = '0;
                    state_next = S_SEL;
                end
                else
                begin
                    state_next = S_COL_RB;
                end
            end
            S_COL_RB:
            begin
                lane_valid_next[SEQ_W'(i_reg)] = map_rdata[COL_W];
                lane_col_next[SEQ_W'(i_reg)]   = map_rdata[COL_W-1:0];
                i_next     = i_reg + 1'b1;
                state_next = S_COL_RA;
            end
            // pick the next mapped row and mark rows sharing its base column
            S_SEL:
            begin
                if (r_reg >= n_eff)
                begin
                    t_next     = t_reg + 1'b1;
                    i_next     = '0;
                    state_next = S_COL_RA;
                end
                else if (!lane_valid_reg[r_idx])
                begin
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    for (k = 0; k < MAX_SEQS; k++)
                    begin
                        mask_next[k] = (32'(k) < 32'(n_eff)) && lane_valid_reg[k]
                                       && (lane_col_reg[k] == lane_col_reg[r_idx]);
                    end
                    x_next     = lane_col_reg[r_idx];
                    i_next     = '0;
                    sum_next   = '0;
                    state_next = S_ACC_RA;
                end
            end
            // walk the marked rows through the distance RAM
            S_ACC_RA:
            begin
                score_raddr = {r_idx, x_reg};
                if (i_reg >= n_eff)
                begin
                    state_next = S_SC_WB;
                end
                else if (mask_reg[SEQ_W'(i_reg)])
                begin
                    state_next = S_ACC_RB;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_ACC_RB:
            begin
                sum_next   = sum_reg + SUM_W'(dist_rdata);
                i_next     = i_reg + 1'b1;
                state_next = S_ACC_RA;
            end
            // add into the score cell with saturation
            S_SC_WB:
            begin
                score_we    = 1'b1;
                score_waddr = {r_idx, x_reg};
                score_wdata = (total > TOT_W'(SCORE_MAX)) ? SCORE_MAX : SCORE_W'(total);
                r_next      = r_reg + 1'b1;
                state_next  = S_SEL;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cmp_reg       <= 1'b0;
            clr_reg       <= '0;
            r_reg         <= '0;
            i_reg         <= '0;
            b_reg         <= '0;
            s_reg         <= '0;
            t_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_reg       <= cmp_next;
            clr_reg       <= clr_next;
            r_reg         <= r_next;
            i_reg         <= i_next;
            b_reg         <= b_next;
            s_reg         <= s_next;
            t_reg         <= t_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_seqs_reg  <= NUM_SEQS_RST;
            base_cols_reg <= COLS_RST;
            test_cols_reg <= COLS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_NUM_SEQS:  num_seqs_reg  <= cfg_data[NSEQ_W-1:0];
                REG_BASE_COLS: base_cols_reg <= cfg_data[NCOL_W-1:0];
                REG_TEST_COLS: test_cols_reg <= cfg_data[NCOL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        sum_reg        <= sum_next;
        mask_reg       <= mask_next;
        lane_valid_reg <= lane_valid_next;
        lane_col_reg   <= lane_col_next;
        score_reg      <= score_next;
        status_reg     <= status_next;
    end

    // stores
    msrpd_ram #(.WIDTH(1), .ADDR_W(CELL_W)) u_base_ram
    (
        .clk   (clk),
        .we    (base_we),
        .waddr (base_waddr),
        .wdata (is_residue),
        .raddr (base_raddr),
        .rdata (base_rdata)
    );

    msrpd_ram #(.WIDTH(1), .ADDR_W(CELL_W)) u_test_ram
    (
        .clk   (clk),
        .we    (test_we),
        .waddr (test_waddr),
        .wdata (is_residue),
        .raddr (test_raddr),
        .rdata (test_rdata)
    );

    msrpd_ram #(.WIDTH(DIST_W), .ADDR_W(PAIR_W)) u_dist_ram
    (
        .clk   (clk),
        .we    (dist_we),
        .waddr (dist_waddr),
        .wdata (distance),
        .raddr (dist_raddr),
        .rdata (dist_rdata)
    );

    msrpd_ram #(.WIDTH(MAP_W), .ADDR_W(CELL_W)) u_map_ram
    (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    msrpd_ram #(.WIDTH(SCORE_W), .ADDR_W(CELL_W)) u_score_ram
    (
        .clk   (clk),
        .we    (score_we),
        .waddr (score_waddr),
        .wdata (score_wdata),
        .raddr (score_raddr),
        .rdata (score_rdata)
    );

    // checks
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while sequencer busy");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (score_we && (score_wdata == '0)))
        else $error("clearing pass wrote a nonzero score");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_IDLE
            || $past(state_reg) == S_RD || $past(state_reg) == S_COL_RA))
        else $error("result raised from an unexpected state");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Testbench for msa_residue_pair_distance_scores: load, compute and read requests
// checked against a score model class. Depends on msrpd_pkg and the block RTL.
`default_nettype none

module tb;
    import msrpd_pkg::*;

    localparam int MAX_SEQS = 16;
    localparam int MAX_COLS = 1024;
    localparam int CELLS    = MAX_SEQS * MAX_COLS;
    localparam int LIMIT    = 3000000;

    // Score model: mirrors the stores and queues the expected results
    class score_model;
        int unsigned nseq;
        int unsigned bcols;
        int unsigned tcols;
        bit          base_flag [CELLS];
        bit          test_flag [CELLS];
        logic [23:0] dist_tab  [MAX_SEQS*MAX_SEQS];
        int          map_col   [CELLS];
        score_t      score_mem [CELLS];
        score_t      want_score [$];
        status_t     want_status [$];
        int          errors;

        function new();
            nseq   = 16;
            bcols  = 1024;
            tcols  = 1024;
            errors = 0;
            foreach (score_mem[k]) score_mem[k] = '0;
            foreach (map_col[k]) map_col[k] = -1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_NUM_SEQS:  nseq  = val[NSEQ_W-1:0];
                REG_BASE_COLS: bcols = val;
                REG_TEST_COLS: tcols = val;
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            return (v > hi) ? hi : v;
        endfunction

        // Pair residues row by row, then accumulate distances per test column
        function void run_compute();
            int unsigned n;
            int unsigned bc;
            int unsigned tc;
            int unsigned b;
            int unsigned s;
            int          x;
            longint unsigned sum;
            n  = clamp(nseq, MAX_SEQS);
            bc = clamp(bcols, MAX_COLS);
            tc = clamp(tcols, MAX_COLS);
            foreach (score_mem[k]) score_mem[k] = '0;
            foreach (map_col[k]) map_col[k] = -1;
            for (int r = 0; r < n; r++) begin
                b = 0;
                s = 0;
                forever begin
                    while (b < bc && !base_flag[r*MAX_COLS + b]) b++;
                    while (s < tc && !test_flag[r*MAX_COLS + s]) s++;
                    if (b >= bc || s >= tc) break;
                    map_col[r*MAX_COLS + s] = b;
                    b++;
                    s++;
                end
            end
            for (int t = 0; t < tc; t++) begin
                for (int r = 0; r < n; r++) begin
                    x = map_col[r*MAX_COLS + t];
                    if (x < 0) continue;
                    sum = 0;
                    for (int i = 0; i < n; i++)
                        if (map_col[i*MAX_COLS + t] == x)
                            sum += dist_tab[i*MAX_SEQS + r];
                    sum += score_mem[r*MAX_COLS + x];
                    score_mem[r*MAX_COLS + x] = (sum > SCORE_MAX) ? SCORE_MAX : score_t'(sum);
                end
            end
        endfunction

        function void note_request(req_t rq, logic [3:0] r, logic [9:0] c, logic [3:0] o,
                                   bit res, logic [23:0] d);
            int unsigned n;
            int unsigned bc;
            int unsigned tc;
            score_t      sc;
            status_t     st;
            n  = clamp(nseq, MAX_SEQS);
            bc = clamp(bcols, MAX_COLS);
            tc = clamp(tcols, MAX_COLS);
            sc = '0;
            st = STATUS_RANGE;
            case (rq)
                REQ_LOAD_BASE:
                    if (r < n && c < bc) begin
                        base_flag[r*MAX_COLS + c] = res;
                        st = STATUS_OK;
                    end
                REQ_LOAD_TEST:
                    if (r < n && c < tc) begin
                        test_flag[r*MAX_COLS + c] = res;
                        st = STATUS_OK;
                    end
                REQ_LOAD_DIST:
                    if (r < n && o < n) begin
                        dist_tab[r*MAX_SEQS + o] = d;
                        st = STATUS_OK;
                    end
                REQ_COMPUTE:
                begin
                    run_compute();
                    st = STATUS_OK;
                end
                REQ_READ:
                    if (r < n && c < bc) begin
                        sc = score_mem[r*MAX_COLS + c];
                        st = STATUS_SCORE;
                    end
                default: ;
            endcase
            want_score  = {want_score, sc};
            want_status = {want_status, st};
        endfunction

        function void check_result(score_t sc, status_t st);
            score_t  es;
            status_t est;
            if (want_score.size() == 0) begin
                $display("%0t: unexpected result score=%h status=%0d", $time, sc, st);
                errors++;
                return;
            end
            es  = want_score.pop_front();
            est = want_status.pop_front();
            if (sc !== es) begin
                $display("%0t: score expected %h actual %h", $time, es, sc);
                errors++;
            end
            if (st !== est) begin
                $display("%0t: status expected %0d actual %0d", $time, est, st);
                errors++;
            end
        endfunction

        function int pending();
            return want_score.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [REQ_W-1:0]      req_type;
    logic [ROW_W-1:0]      row;
    logic [COLUMN_W-1:0]   column;
    logic [ROW_W-1:0]      other_row;
    logic                  is_residue;
    logic [DIST_W-1:0]     distance;
    logic                  out_valid;
    logic                  out_stall;
    logic [SCORE_W-1:0]    score;
    logic [STATUS_W-1:0]   status;

    score_model  scores;
    bit          quiet;
    bit          hold_out;
    int unsigned cycles;

    msa_residue_pair_distance_scores DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .row        (row),
        .column     (column),
        .other_row  (other_row),
        .is_residue (is_residue),
        .distance   (distance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .score      (score),
        .status     (status)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("msa_residue_pair_distance_scores test failed");
            $finish;
        end
    end

    // Drive result stall: random bursts, one long hold on request
    initial
    begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_out) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_out = 1'b0;
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Check each result at the edge where it leaves
    initial
    begin
        forever begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                scores.check_result(score, status);
        end
    end

    // Offer one request and hold it until taken
    task automatic send(req_t rq, logic [3:0] r, logic [9:0] c, logic [3:0] o,
                        bit res, logic [23:0] d);
        bit taken;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        row        <= r;
        column     <= c;
        other_row  <= o;
        is_residue <= res;
        distance   <= d;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        scores.note_request(rq, r, c, o, res, d);
    endtask

    // Drop valid and wait until every expected result is back
    task automatic settle();
        in_valid <= 1'b0;
        while (scores.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_config(logic [10:0] n, logic [10:0] bc, logic [10:0] tc);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_NUM_SEQS;
        cfg_data  <= n;
        @(posedge clk);
        scores.set_reg(REG_NUM_SEQS, n);
        cfg_index <= REG_BASE_COLS;
        cfg_data  <= bc;
        @(posedge clk);
        scores.set_reg(REG_BASE_COLS, bc);
        cfg_index <= REG_TEST_COLS;
        cfg_data  <= tc;
        @(posedge clk);
        scores.set_reg(REG_TEST_COLS, tc);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [3:0] pick_row(int n);
        if ($urandom_range(0, 9) < 8) return 4'($urandom_range(0, n - 1));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [9:0] pick_col(int w);
        if ($urandom_range(0, 9) < 8) return 10'($urandom_range(0, w - 1));
        return 10'($urandom_range(0, 1023));
    endfunction

    // Random mix of loads, reads and unknown requests
    task automatic random_mix(int n, int bc, int tc, int count);
        int   pick;
        req_t rq;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)      rq = REQ_LOAD_BASE;
            else if (pick < 50) rq = REQ_LOAD_TEST;
            else if (pick < 62) rq = REQ_LOAD_DIST;
            else if (pick < 92) rq = REQ_READ;
            else                rq = req_t'($urandom_range(5, 7));
            send(rq, pick_row(n), pick_col((rq == REQ_LOAD_TEST) ? tc : bc), pick_row(n),
                 1'($urandom_range(0, 1)), 24'($urandom));
        end
    endtask

    // Fill both alignments and the distance table, compute, run a random mix, compute again, then read back
    task automatic run_phase(int n, int bc, int tc, bit max_dist, int pct, int count);
        set_config(11'(n), 11'(bc), 11'(tc));
        for (int r = 0; r < n; r++)
            for (int c = 0; c < bc; c++)
                send(REQ_LOAD_BASE, 4'(r), 10'(c), 4'd0, $urandom_range(0, 99) < pct,
                     24'($urandom));
        for (int r = 0; r < n; r++)
            for (int c = 0; c < tc; c++)
                send(REQ_LOAD_TEST, 4'(r), 10'(c), 4'd0, $urandom_range(0, 99) < pct,
                     24'($urandom));
        for (int r = 0; r < n; r++)
            for (int o = 0; o < n; o++)
                send(REQ_LOAD_DIST, 4'(r), 10'($urandom), 4'(o), 1'($urandom_range(0, 1)),
                     max_dist ? 24'hFFFFFF : 24'($urandom));
        send(REQ_COMPUTE, 4'($urandom), 10'($urandom), 4'($urandom),
             1'($urandom_range(0, 1)), 24'($urandom));
        random_mix(n, bc, tc, count);
        send(REQ_COMPUTE, 4'($urandom), 10'($urandom), 4'($urandom),
             1'($urandom_range(0, 1)), 24'($urandom));
        for (int r = 0; r < n; r++)
            for (int c = 0; c < bc; c++)
                send(REQ_READ, 4'(r), 10'(c), 4'($urandom), 1'($urandom_range(0, 1)),
                     24'($urandom));
    endtask

    initial
    begin
        scores     = new();
        cycles     = 0;
        quiet      = 1'b0;
        hold_out   = 1'b0;
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = REG_NUM_SEQS;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = REQ_LOAD_BASE;
        row        = '0;
        column     = '0;
        other_row  = '0;
        is_residue = 1'b0;
        distance   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset sizes, field extremes, unknown requests
        send(REQ_READ, 4'd0, 10'd0, 4'd0, 1'b0, 24'd0);
        send(REQ_READ, 4'd15, 10'd1023, 4'd15, 1'b1, 24'hFFFFFF);
        send(REQ_LOAD_BASE, 4'd15, 10'd1023, 4'd0, 1'b1, 24'd0);
        send(REQ_LOAD_TEST, 4'd15, 10'd1023, 4'd15, 1'b0, 24'hFFFFFF);
        send(REQ_LOAD_DIST, 4'd15, 10'd0, 4'd15, 1'b1, 24'hFFFFFF);
        send(REQ_LOAD_DIST, 4'd0, 10'd1023, 4'd0, 1'b0, 24'd0);
        send(req_t'(5), 4'd15, 10'd1023, 4'd15, 1'b1, 24'hFFFFFF);
        send(req_t'(6), 4'd0, 10'd0, 4'd0, 1'b0, 24'd0);
        send(req_t'(7), 4'd7, 10'd512, 4'd3, 1'b1, 24'h800000);

        // Register values above the maximum are clamped
        set_config(11'd31, 11'd2047, 11'd2047);
        send(REQ_LOAD_BASE, 4'd15, 10'd1023, 4'd0, 1'b0, 24'd0);
        send(REQ_READ, 4'd15, 10'd1023, 4'd0, 1'b0, 24'd0);

        // Zero sizes: compute maps nothing, everything else out of range
        set_config(11'd0, 11'd0, 11'd0);
        send(REQ_COMPUTE, 4'd0, 10'd0, 4'd0, 1'b0, 24'd0);
        send(REQ_LOAD_BASE, 4'd0, 10'd0, 4'd0, 1'b1, 24'd0);
        send(REQ_LOAD_TEST, 4'd0, 10'd0, 4'd0, 1'b1, 24'd0);
        send(REQ_LOAD_DIST, 4'd0, 10'd0, 4'd0, 1'b1, 24'd5);
        send(REQ_READ, 4'd0, 10'd0, 4'd0, 1'b0, 24'd0);

        // Single row, single column
        run_phase(1, 1, 1, 1'b0, 100, 4);

        // Long result hold while loads keep coming
        hold_out = 1'b1;
        run_phase(3, 8, 10, 1'b0, 70, 40);
        run_phase(4, 12, 12, 1'b1, 95, 20);
        run_phase(16, 3, 4, 1'b0, 60, 20);
        run_phase(2, 20, 12, 1'b0, 50, 40);

        // Last part runs without idling
        settle();
        quiet = 1'b1;
        run_phase(5, 10, 10, 1'b1, 80, 40);

        // Restore full sizes and run a random mix of loads and reads after a size change
        set_config(11'd16, 11'd1024, 11'd1024);
        random_mix(16, 1024, 1024, 10);

        settle();
        if (scores.errors == 0)
            $display("msa_residue_pair_distance_scores test passed");
        else
            $display("msa_residue_pair_distance_scores test failed");
        $finish;
    end

endmodule

`default_nettype wire
